// File: rtl/core/lpn2sc_pkg.sv
// Shared types and constants for the length-prefixed NAL to start-code converter.
// No dependencies; used by lpn2sc_parser and the top level.
package lpn2sc_pkg;

  localparam int OUT_COUNT_BITS = 24;
  localparam int CAP_BITS       = 24;
  localparam int LEN_BITS       = 32;
  localparam int SUM_BITS       = 34;

  localparam logic [32:0] OUT_LIMIT = (33'd1 << OUT_COUNT_BITS) - 33'd1;

  localparam logic [2:0] FIELD_RESET    = 3'd4;
  localparam logic [2:0] FIELD_MIN      = 3'd1;
  localparam logic [2:0] FIELD_MAX      = 3'd4;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 24'hFFFFFF;

  localparam logic [2:0] START_LEN  = 3'd4;
  localparam logic [7:0] START_ZERO = 8'h00;
  localparam logic [7:0] START_LAST = 8'h01;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_TRUNC = 2'd2,
    ST_OVER  = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    REG_FIELD_BYTES = 1'b0,
    REG_CAPACITY    = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    RES_NONE = 2'd0,
    RES_ONE  = 2'd1,
    RES_SEQ  = 2'd2
  } res_kind_t;

  typedef struct packed {
    res_kind_t  kind;
    logic [7:0] data;
    logic       valid;
    logic       last;
    status_t    status;
  } res_t;

endpackage

// File: rtl/core/length_prefixed_nal_to_start_codes.sv
// Top level: AVCC length-prefixed NAL stream to Annex B start codes.
// Depends on lpn2sc_pkg and lpn2sc_parser.
// The first result word of an accepted input word is registered for the next cycle.
// Throughput: 1 word per cycle for length and payload bytes while the output is not
//   stalled; input waits while a start code leaves the single register as 4 words.
// Reset: synchronous rst clears parse state and the result word count and sets
//   length_field_bytes to 4 and output_capacity to 16777215; result data is not reset.
module length_prefixed_nal_to_start_codes (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic                            cfg_addr,
  input  logic [lpn2sc_pkg::CAP_BITS-1:0] cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] in_byte
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,   // [7:0] out_byte
  output logic [2:0]                      m_tuser,   // [0] byte_valid, [2:1] status
  output logic                            m_tlast
);

  lpn2sc_pkg::res_t    res;
  logic                s_acc;
  logic                m_acc;
  logic [2:0]          cnt;
  logic                seq;
  logic [7:0]          data;
  logic                valid;
  logic                last;
  lpn2sc_pkg::status_t status;

  assign m_acc    = m_tvalid && m_tready;
  assign s_tready = (cnt == 3'd0) || (cnt == 3'd1 && m_tready);
  assign s_acc    = s_tvalid && s_tready;

  lpn2sc_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .accept    (s_acc),
    .in_byte   (s_tdata),
    .in_last   (s_tlast),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
      seq <= 1'b0;
    end else if (s_acc && res.kind == lpn2sc_pkg::RES_SEQ) begin
      cnt <= lpn2sc_pkg::START_LEN;
      seq <= 1'b1;
    end else if (s_acc && res.kind == lpn2sc_pkg::RES_ONE) begin
      cnt <= 3'd1;
      seq <= 1'b0;
    end else if (m_acc) begin
      cnt <= cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc && res.kind != lpn2sc_pkg::RES_NONE) begin
      data   <= res.data;
      valid  <= res.valid;
      last   <= res.last;
      status <= res.status;
    end
  end

  assign m_tvalid = (cnt != 3'd0);
  assign m_tdata  = seq ? ((cnt == 3'd1) ? lpn2sc_pkg::START_LAST : lpn2sc_pkg::START_ZERO)
                        : data;
  assign m_tuser  = {status, valid};
  assign m_tlast  = last;

`ifndef SYNTHESIS
  a_seq_load: assert property (@(posedge clk) disable iff (rst)
    (s_acc && res.kind == lpn2sc_pkg::RES_SEQ) |=> (cnt == lpn2sc_pkg::START_LEN && seq))
    else $error("start code not loaded as four words");

  a_drop_has_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast && !m_tuser[0]) |-> (m_tuser[2:1] != lpn2sc_pkg::ST_OK))
    else $error("empty end word without error status");

  a_mid_status_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tuser[2:1] == lpn2sc_pkg::ST_OK && m_tuser[0]))
    else $error("non-final word carries status or no byte");
`endif

endmodule

// File: rtl/core/lpn2sc_parser.sv
// Per-sample parse state, configuration registers and result decision for one word.
// Depends on lpn2sc_pkg.
module lpn2sc_parser (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_addr,
  input  logic [lpn2sc_pkg::CAP_BITS-1:0] cfg_data,
  input  logic                           accept,
  input  logic [7:0]                     in_byte,
  input  logic                           in_last,
  output lpn2sc_pkg::res_t               res
);

  logic [2:0]                              field_bytes;
  logic [lpn2sc_pkg::CAP_BITS-1:0]         capacity;

  logic                                    in_payload, in_payload_next;
  logic [1:0]                              seen, seen_next;
  logic [lpn2sc_pkg::LEN_BITS-1:0]         acc, acc_next;
  logic [lpn2sc_pkg::LEN_BITS-1:0]         left, left_next;
  logic [lpn2sc_pkg::OUT_COUNT_BITS-1:0]   written, written_next;
  lpn2sc_pkg::status_t                     err, err_next;

  logic [2:0]                              field_len;
  logic [32:0]                             cap_ext;
  logic [32:0]                             cap_eff;
  logic [lpn2sc_pkg::LEN_BITS-1:0]         acc_shift;
  logic [lpn2sc_pkg::SUM_BITS-1:0]         need;
  logic                                    complete;
  lpn2sc_pkg::status_t                     chk;

  always_comb begin
    if (field_bytes < lpn2sc_pkg::FIELD_MIN) begin
      field_len = lpn2sc_pkg::FIELD_MIN;
    end else if (field_bytes > lpn2sc_pkg::FIELD_MAX) begin
      field_len = lpn2sc_pkg::FIELD_MAX;
    end else begin
      field_len = field_bytes;
    end
  end

  assign cap_ext   = 33'(capacity);
  assign cap_eff   = (cap_ext < lpn2sc_pkg::OUT_LIMIT) ? cap_ext : lpn2sc_pkg::OUT_LIMIT;
  assign acc_shift = {acc[lpn2sc_pkg::LEN_BITS-9:0], in_byte};
  assign need      = lpn2sc_pkg::SUM_BITS'(written) + lpn2sc_pkg::SUM_BITS'(acc_shift)
                     + lpn2sc_pkg::SUM_BITS'(lpn2sc_pkg::START_LEN);
  assign complete  = (3'(seen) + 3'd1) >= field_len;

  always_comb begin
    if (acc_shift == '0) begin
      chk = lpn2sc_pkg::ST_ZERO;
    end else if (in_last) begin
      chk = lpn2sc_pkg::ST_TRUNC;
    end else if (need > lpn2sc_pkg::SUM_BITS'(cap_eff)) begin
      chk = lpn2sc_pkg::ST_OVER;
    end else begin
      chk = lpn2sc_pkg::ST_OK;
    end
  end

  always_comb begin
    in_payload_next = in_payload;
    seen_next       = seen;
    acc_next        = acc;
    left_next       = left;
    written_next    = written;
    err_next        = err;
    res.kind        = lpn2sc_pkg::RES_NONE;
    res.data        = 8'h00;
    res.valid       = 1'b0;
    res.last        = 1'b0;
    res.status      = lpn2sc_pkg::ST_OK;
    if (accept) begin
      if (err != lpn2sc_pkg::ST_OK) begin
        if (in_last) begin
          res.kind   = lpn2sc_pkg::RES_ONE;
          res.last   = 1'b1;
          res.status = err;
        end
      end else if (in_payload) begin
        if (in_last && left > 32'd1) begin
          res.kind   = lpn2sc_pkg::RES_ONE;
          res.last   = 1'b1;
          res.status = lpn2sc_pkg::ST_TRUNC;
        end else begin
          left_next    = left - 32'd1;
          written_next = written + lpn2sc_pkg::OUT_COUNT_BITS'(1);
          if (left == 32'd1) begin
            in_payload_next = 1'b0;
            seen_next       = 2'd0;
            acc_next        = '0;
          end
          res.kind  = lpn2sc_pkg::RES_ONE;
          res.data  = in_byte;
          res.valid = 1'b1;
          res.last  = in_last;
        end
      end else if (complete) begin
        if (chk != lpn2sc_pkg::ST_OK) begin
          if (in_last) begin
            res.kind   = lpn2sc_pkg::RES_ONE;
            res.last   = 1'b1;
            res.status = chk;
          end else begin
            err_next = chk;
          end
        end else begin
          res.kind        = lpn2sc_pkg::RES_SEQ;
          res.valid       = 1'b1;
          written_next    = written + lpn2sc_pkg::OUT_COUNT_BITS'(lpn2sc_pkg::START_LEN);
          left_next       = acc_shift;
          in_payload_next = 1'b1;
          seen_next       = 2'd0;
          acc_next        = '0;
        end
      end else if (in_last) begin
        res.kind   = lpn2sc_pkg::RES_ONE;
        res.last   = 1'b1;
        res.status = lpn2sc_pkg::ST_TRUNC;
      end else begin
        seen_next = seen + 2'd1;
        acc_next  = acc_shift;
      end
      if (in_last) begin
        in_payload_next = 1'b0;
        seen_next       = 2'd0;
        acc_next        = '0;
        left_next       = '0;
        written_next    = '0;
        err_next        = lpn2sc_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_bytes <= lpn2sc_pkg::FIELD_RESET;
      capacity    <= lpn2sc_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        lpn2sc_pkg::REG_FIELD_BYTES: field_bytes <= cfg_data[2:0];
        lpn2sc_pkg::REG_CAPACITY:    capacity    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload <= 1'b0;
      seen       <= 2'd0;
      acc        <= '0;
      left       <= '0;
      written    <= '0;
      err        <= lpn2sc_pkg::ST_OK;
    end else begin
      in_payload <= in_payload_next;
      seen       <= seen_next;
      acc        <= acc_next;
      left       <= left_next;
      written    <= written_next;
      err        <= err_next;
    end
  end

endmodule

// File: test/nal_stream_checker.sv
// Checker for the length-prefixed NAL to start-code converter: tracks config writes,
// predicts the output words of every accepted input word and compares them in order.
// Depends on lpn2sc_pkg.
module nal_stream_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_addr,
  input  logic [lpn2sc_pkg::CAP_BITS-1:0] cfg_data,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] in_byte
  input  logic                           s_tlast,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [7:0]                     m_tdata,   // [7:0] out_byte
  input  logic [2:0]                     m_tuser,   // [0] byte_valid, [2:1] status
  input  logic                           m_tlast,
  output int                             fail_count,
  output int                             pending
);

  typedef struct packed {
    logic [7:0]          data;
    logic                valid;
    logic                eop;
    lpn2sc_pkg::status_t status;
  } nal_word_t;

  nal_word_t expected_words[$];

  logic [2:0]                      field_cfg = lpn2sc_pkg::FIELD_RESET;
  logic [lpn2sc_pkg::CAP_BITS-1:0] cap_cfg   = lpn2sc_pkg::CAP_RESET;

  logic                in_unit;
  logic [1:0]          len_seen;
  logic [31:0]         len_acc;
  logic [31:0]         unit_left;
  longint unsigned     out_count;
  lpn2sc_pkg::status_t held_err;

  function automatic int prefix_width();
    if (field_cfg == 3'd0) return 1;
    if (field_cfg > 3'd4) return 4;
    return int'(field_cfg);
  endfunction

  function automatic longint unsigned cap_limit();
    longint unsigned lim;
    lim = (64'd1 << lpn2sc_pkg::OUT_COUNT_BITS) - 64'd1;
    return (longint'(cap_cfg) < lim) ? longint'(cap_cfg) : lim;
  endfunction

  task automatic clear_sample_state();
    in_unit   = 1'b0;
    len_seen  = '0;
    len_acc   = '0;
    unit_left = '0;
    out_count = 0;
    held_err  = lpn2sc_pkg::ST_OK;
  endtask

  task automatic push_word(input logic [7:0] d, input logic v, input logic e,
                           input lpn2sc_pkg::status_t s);
    expected_words.push_back('{data: d, valid: v, eop: e, status: s});
  endtask

  task automatic convert_byte(input logic [7:0] b, input logic eop);
    lpn2sc_pkg::status_t err;
    int                  seen_count;
    if (held_err != lpn2sc_pkg::ST_OK) begin
      if (eop) begin
        push_word(8'h00, 1'b0, 1'b1, held_err);
        clear_sample_state();
      end
      return;
    end
    if (in_unit) begin
      if (eop && unit_left > 32'd1) begin
        push_word(8'h00, 1'b0, 1'b1, lpn2sc_pkg::ST_TRUNC);
        clear_sample_state();
        return;
      end
      unit_left = unit_left - 32'd1;
      out_count = out_count + 1;
      if (unit_left == 32'd0) begin
        in_unit  = 1'b0;
        len_seen = '0;
        len_acc  = '0;
      end
      push_word(b, 1'b1, eop, lpn2sc_pkg::ST_OK);
      if (eop) clear_sample_state();
      return;
    end
    len_acc    = {len_acc[23:0], b};
    len_seen   = len_seen + 2'd1;
    seen_count = (len_seen == 2'd0) ? 4 : int'(len_seen);
    if (seen_count >= prefix_width()) begin
      err = lpn2sc_pkg::ST_OK;
      if (len_acc == 32'd0) err = lpn2sc_pkg::ST_ZERO;
      else if (eop) err = lpn2sc_pkg::ST_TRUNC;
      else if (out_count + 4 + longint'(len_acc) > cap_limit()) err = lpn2sc_pkg::ST_OVER;
      if (err != lpn2sc_pkg::ST_OK) begin
        if (eop) begin
          push_word(8'h00, 1'b0, 1'b1, err);
          clear_sample_state();
        end else begin
          held_err = err;
        end
        return;
      end
      push_word(lpn2sc_pkg::START_ZERO, 1'b1, 1'b0, lpn2sc_pkg::ST_OK);
      push_word(lpn2sc_pkg::START_ZERO, 1'b1, 1'b0, lpn2sc_pkg::ST_OK);
      push_word(lpn2sc_pkg::START_ZERO, 1'b1, 1'b0, lpn2sc_pkg::ST_OK);
      push_word(lpn2sc_pkg::START_LAST, 1'b1, 1'b0, lpn2sc_pkg::ST_OK);
      out_count = out_count + 4;
      unit_left = len_acc;
      in_unit   = 1'b1;
      len_seen  = '0;
      len_acc   = '0;
      return;
    end
    if (eop) begin
      push_word(8'h00, 1'b0, 1'b1, lpn2sc_pkg::ST_TRUNC);
      clear_sample_state();
    end
  endtask

  initial clear_sample_state();

  always @(posedge clk) begin : watch
    nal_word_t got;
    nal_word_t want;
    int        nbad;
    nbad = 0;
    if (rst) begin
      field_cfg = lpn2sc_pkg::FIELD_RESET;
      cap_cfg   = lpn2sc_pkg::CAP_RESET;
      clear_sample_state();
      expected_words.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{data: m_tdata, valid: m_tuser[0], eop: m_tlast,
                status: lpn2sc_pkg::status_t'(m_tuser[2:1])};
        if (expected_words.size() == 0) begin
          $error("unexpected word: out_byte=%0h byte_valid=%0b sample_end=%0b status=%0d",
                 got.data, got.valid, got.eop, got.status);
          nbad++;
        end else begin
          want = expected_words.pop_front();
          if (got.data !== want.data) begin
            $error("out_byte: expected %0h, got %0h", want.data, got.data);
            nbad++;
          end
          if (got.valid !== want.valid) begin
            $error("byte_valid: expected %0b, got %0b", want.valid, got.valid);
            nbad++;
          end
          if (got.eop !== want.eop) begin
            $error("sample_end: expected %0b, got %0b", want.eop, got.eop);
            nbad++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            nbad++;
          end
        end
      end
      if (s_tvalid && s_tready) convert_byte(s_tdata, s_tlast);
      if (cfg_wr_en) begin
        if (cfg_addr == lpn2sc_pkg::REG_FIELD_BYTES) field_cfg = cfg_data[2:0];
        else cap_cfg = cfg_data;
      end
    end
    fail_count <= fail_count + nbad;
    pending    <= expected_words.size();
  end

endmodule

// File: test/tb_top.sv
// Testbench top for length_prefixed_nal_to_start_codes: drives directed and random
// samples under several length-prefix and capacity settings with bursty input and
// stalling output. Depends on lpn2sc_pkg, the DUT and nal_stream_checker.
module tb_top;

  localparam int CYCLE_LIMIT = 200000;

  logic                            clk;
  logic                            rst       = 1'b1;
  logic                            cfg_wr_en = 1'b0;
  logic                            cfg_addr  = 1'b0;
  logic [lpn2sc_pkg::CAP_BITS-1:0] cfg_data  = '0;
  logic                            s_tvalid  = 1'b0;
  logic                            s_tready;
  logic [7:0]                      s_tdata   = '0;
  logic                            s_tlast   = 1'b0;
  logic                            m_tvalid;
  logic                            m_tready  = 1'b0;
  logic [7:0]                      m_tdata;
  logic [2:0]                      m_tuser;
  logic                            m_tlast;

  int fail_count;
  int pending;
  int cycles      = 0;
  int burst_left  = 0;
  int gen_width   = 4;

  length_prefixed_nal_to_start_codes i_dut (
    .clk, .rst, .cfg_wr_en, .cfg_addr, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
  );

  nal_stream_checker i_checker (
    .clk, .rst, .cfg_wr_en, .cfg_addr, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // output stall pattern: switch to a random mode each time stall_cnt wraps
  int       stall_mode = 0;
  bit [5:0] stall_cnt  = '0;
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 6'd1;
    if (stall_cnt == 6'd63) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= (stall_cnt[1:0] == 2'd0);
      default: m_tready <= ~stall_cnt[2];
    endcase
  end

  task automatic send_word(input logic [7:0] b, input logic eop);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eop;
    do @(posedge clk); while (!s_tready);
    burst_left--;
  endtask

  task automatic send_sample(input logic [7:0] q[$]);
    foreach (q[i]) send_word(q[i], i == q.size() - 1);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input lpn2sc_pkg::reg_index_t idx,
                           input logic [lpn2sc_pkg::CAP_BITS-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [2:0] fld,
                            input logic [lpn2sc_pkg::CAP_BITS-1:0] cap);
    settle();
    cfg_write(lpn2sc_pkg::REG_FIELD_BYTES, lpn2sc_pkg::CAP_BITS'(fld));
    cfg_write(lpn2sc_pkg::REG_CAPACITY, cap);
    gen_width = (fld == 3'd0) ? 1 : (fld > 3'd4) ? 4 : int'(fld);
  endtask

  // mostly well-formed units; some cut short, some zero-length, some noise
  function automatic void build_sample(input int width, output logic [7:0] q[$]);
    int kind;
    int units;
    int len;
    int cut;
    q = {};
    kind = $urandom_range(0, 9);
    if (kind == 8) begin
      repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    units = $urandom_range(1, 3);
    for (int u = 0; u < units; u++) begin
      len = (kind == 9 && u == units - 1) ? 0 : $urandom_range(1, 5);
      for (int i = width - 1; i >= 0; i--) q.push_back(8'(len >> (8 * i)));
      repeat (len) q.push_back(8'($urandom_range(0, 255)));
    end
    if (kind == 9) repeat ($urandom_range(0, 3)) q.push_back(8'($urandom_range(0, 255)));
    if (kind == 7) begin
      cut = $urandom_range(1, q.size() - 1);
      while (q.size() > cut) void'(q.pop_back());
    end
  endfunction

  initial begin
    logic [7:0]                      smp[$];
    int                              sent;
    logic [2:0]                      fld;
    logic [lpn2sc_pkg::CAP_BITS-1:0] cap;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_config(3'd1, lpn2sc_pkg::CAP_RESET);
    send_sample('{8'h02, 8'h00, 8'hFF});
    send_sample('{8'h00, 8'hAA, 8'h55});
    send_sample('{8'h00});
    send_sample('{8'h03});
    send_sample('{8'h03, 8'h11, 8'h22});
    set_config(3'd0, lpn2sc_pkg::CAP_RESET);
    send_sample('{8'h01, 8'hC3});
    set_config(3'd7, lpn2sc_pkg::CAP_RESET);
    send_sample('{8'h00, 8'h00, 8'h00, 8'h01, 8'h5A});
    set_config(3'd1, '0);
    send_sample('{8'h01, 8'h33});
    set_config(3'd1, 24'd5);
    send_sample('{8'h01, 8'hAA, 8'h01, 8'hBB});

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin fld = 3'd4; cap = lpn2sc_pkg::CAP_RESET; end
        1: begin fld = 3'd1; cap = lpn2sc_pkg::CAP_BITS'($urandom_range(6, 24)); end
        2: begin fld = 3'd2; cap = lpn2sc_pkg::CAP_RESET; end
        3: begin fld = 3'd3; cap = lpn2sc_pkg::CAP_BITS'($urandom_range(0, 12)); end
        default: begin
          fld = 3'($urandom_range(0, 7));
          cap = $urandom_range(0, 1) ? lpn2sc_pkg::CAP_RESET
                                     : lpn2sc_pkg::CAP_BITS'($urandom_range(4, 30));
        end
      endcase
      set_config(fld, cap);
      sent = 0;
      while (sent < 12) begin
        build_sample(gen_width, smp);
        send_sample(smp);
        sent += smp.size();
      end
    end

    settle();
    repeat (16) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
